[hdl/cdiv_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdiv_pkg
// shared types and constants of the complex divider
// ----------------------------------------------------------------------------
package cdiv_pkg;

    localparam int WORD_W  = 32;
    localparam int PROD_W  = 64;
    localparam int Q_FRAC  = 16;
    localparam int R_FRAC  = 30;
    // ratio quotient bits 30..0, part quotient bits 32..0
    localparam int RQ_BITS = R_FRAC + 1;
    localparam int PQ_BITS = 33;
    // magnitude of the combined denominator and numerators
    localparam int MAG_W   = 63;

    localparam logic [WORD_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] NEG_MAX = 32'h8000_0000;

    // operands carried alongside the ratio divider
    typedef struct packed {
        logic signed [WORD_W-1:0] x;
        logic signed [WORD_W-1:0] y;
        logic signed [WORD_W-1:0] pivot;
        logic signed [WORD_W-1:0] other;
        logic                     swp;
        logic                     zero;
        logic                     rneg;
    } ratio_side_t;

    // per-part flags carried alongside the part divider
    typedef struct packed {
        logic ovf;
        logic neg;
    } part_side_t;

    typedef struct packed {
        logic       zero;
        part_side_t part;
    } re_side_t;

endpackage
`default_nettype wire

[hdl/cdiv_udiv.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdiv_udiv
// pipelined restoring unsigned divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module cdiv_udiv #(
    parameter  int QB = 31,
    parameter  int DW = 32,
    parameter  int SW = 1,
    localparam int RW = DW + QB - 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [RW-1:0] in_rem,
    input  wire logic [DW-1:0] in_div,
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    output logic [QB-1:0]      out_quot,
    output logic [SW-1:0]      out_side
);

    logic          valid_reg [QB];
    logic [RW-1:0] rem_reg   [QB];
    logic [QB-1:0] quot_reg  [QB];
    logic [DW-1:0] div_reg   [QB];
    logic [SW-1:0] side_reg  [QB];

    for (genvar g = 0; g < QB; g++) begin : g_stage
        logic          valid_prev;
        logic [RW-1:0] rem_prev;
        logic [QB-1:0] quot_prev;
        logic [DW-1:0] div_prev;
        logic [SW-1:0] side_prev;
        logic [RW-1:0] shifted;
        logic          take;
        logic [RW-1:0] rem_next;
        logic [QB-1:0] quot_next;

        if (g == 0) begin : g_first
            assign valid_prev = in_valid;
            assign rem_prev   = in_rem;
            assign quot_prev  = '0;
            assign div_prev   = in_div;
            assign side_prev  = in_side;
        end else begin : g_rest
            assign valid_prev = valid_reg[g-1];
            assign rem_prev   = rem_reg[g-1];
            assign quot_prev  = quot_reg[g-1];
            assign div_prev   = div_reg[g-1];
            assign side_prev  = side_reg[g-1];
        end

        // trial subtract of the divisor at this quotient weight
        always_comb
        begin
            shifted   = RW'(div_prev) << (QB - 1 - g);
            take      = rem_prev >= shifted;
            rem_next  = take ? rem_prev - shifted : rem_prev;
            quot_next = quot_prev;
            quot_next[QB-1-g] = take;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[g] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= rem_next;
                quot_reg[g] <= quot_next;
                div_reg[g]  <= div_prev;
                side_reg[g] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[QB-1];
    assign out_quot  = quot_reg[QB-1];
    assign out_side  = side_reg[QB-1];

endmodule
`default_nettype wire

[hdl/complex_divide.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// complex_divide
// pipelined complex divider, Smith's method, signed Q16.16
// ----------------------------------------------------------------------------
//  channel  handshake          payload
//  in       in_valid/in_stall  num_re num_im den_re den_im
//  out      out_valid/out_stall quot_re quot_im div_by_zero saturated
//
//  one transaction per cycle while the output is not stalled; stages: input decode, 31 ratio
//  stages (one quotient bit each), multiply, sum, magnitude, 33 part
//  divide stages, output register
//  reset clears the valid bits only; payload registers are not reset
//  a stall on the output freezes the whole pipeline, so nothing is lost
//  or repeated; in_stall follows out_stall while a result is waiting
// ----------------------------------------------------------------------------
module complex_divide (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] num_re,
    input  wire logic signed [31:0] num_im,
    input  wire logic signed [31:0] den_re,
    input  wire logic signed [31:0] den_im,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      quot_re,
    output logic signed [31:0]      quot_im,
    output logic                    div_by_zero,
    output logic                    saturated
);
    import cdiv_pkg::*;

    localparam int RSIDE_W = $bits(ratio_side_t);
    localparam int RRW     = WORD_W + RQ_BITS - 1;
    localparam int PRW     = MAG_W + PQ_BITS - 1;

    // whole pipeline advances unless a finished result is held
    logic out_valid_reg;
    logic en;
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // ---------------- input decode: pick the pivot ----------------
    logic [WORD_W-1:0] re_mag;
    logic [WORD_W-1:0] im_mag;
    ratio_side_t       pre_side_next;
    logic [WORD_W-1:0] pmag_next;
    logic [WORD_W-1:0] omag_next;

    always_comb
    begin
        re_mag = den_re[WORD_W-1] ? $unsigned(-den_re) : $unsigned(den_re);
        im_mag = den_im[WORD_W-1] ? $unsigned(-den_im) : $unsigned(den_im);
        // equal magnitudes keep the real part as pivot
        pre_side_next.swp   = re_mag < im_mag;
        pre_side_next.x     = num_re;
        pre_side_next.y     = num_im;
        pre_side_next.pivot = pre_side_next.swp ? den_im : den_re;
        pre_side_next.other = pre_side_next.swp ? den_re : den_im;
        pre_side_next.zero  = (den_re == '0) && (den_im == '0);
        pre_side_next.rneg  = den_re[WORD_W-1] ^ den_im[WORD_W-1];
        pmag_next = pre_side_next.swp ? im_mag : re_mag;
        omag_next = pre_side_next.swp ? re_mag : im_mag;
    end

    logic              pre_valid_reg;
    ratio_side_t       pre_side_reg;
    logic [WORD_W-1:0] pmag_reg;
    logic [WORD_W-1:0] omag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pre_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_side_reg <= pre_side_next;
            pmag_reg     <= pmag_next;
            omag_reg     <= omag_next;
        end
    end

    // ---------------- ratio |other| * 2^30 / |pivot| ----------------
    logic               rdiv_valid;
    logic [RQ_BITS-1:0] rdiv_quot;
    logic [RSIDE_W-1:0] rdiv_side_bits;
    ratio_side_t        rdiv_side;

    cdiv_udiv #(
        .QB(RQ_BITS),
        .DW(WORD_W),
        .SW(RSIDE_W)
    ) u_ratio (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (pre_valid_reg),
        .in_rem   ({omag_reg, {R_FRAC{1'b0}}}),
        .in_div   (pmag_reg),
        .in_side  (pre_side_reg),
        .out_valid(rdiv_valid),
        .out_quot (rdiv_quot),
        .out_side (rdiv_side_bits)
    );

    assign rdiv_side = ratio_side_t'(rdiv_side_bits);

    // ratio truncated toward zero, |r| <= 2^30
    logic signed [WORD_W-1:0] ratio;
    assign ratio = rdiv_side.rneg ? -$signed({1'b0, rdiv_quot})
                                  :  $signed({1'b0, rdiv_quot});

    // ---------------- products ----------------
    logic                     mul_valid_reg;
    logic signed [PROD_W-1:0] prod_ro_reg;
    logic signed [PROD_W-1:0] prod_yr_reg;
    logic signed [PROD_W-1:0] prod_xr_reg;
    logic signed [WORD_W-1:0] mul_x_reg;
    logic signed [WORD_W-1:0] mul_y_reg;
    logic signed [WORD_W-1:0] mul_p_reg;
    logic                     mul_swp_reg;
    logic                     mul_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_valid_reg <= rdiv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_ro_reg  <= PROD_W'(ratio) * PROD_W'(rdiv_side.other);
            prod_yr_reg  <= PROD_W'(rdiv_side.y) * PROD_W'(ratio);
            prod_xr_reg  <= PROD_W'(rdiv_side.x) * PROD_W'(ratio);
            mul_x_reg    <= rdiv_side.x;
            mul_y_reg    <= rdiv_side.y;
            mul_p_reg    <= rdiv_side.pivot;
            mul_swp_reg  <= rdiv_side.swp;
            mul_zero_reg <= rdiv_side.zero;
        end
    end

    // ---------------- denominator and numerators at scale 2^46 ----------------
    logic signed [PROD_W-1:0] x_sc;
    logic signed [PROD_W-1:0] y_sc;
    logic signed [PROD_W-1:0] p_sc;
    assign x_sc = PROD_W'(mul_x_reg) <<< R_FRAC;
    assign y_sc = PROD_W'(mul_y_reg) <<< R_FRAC;
    assign p_sc = PROD_W'(mul_p_reg) <<< R_FRAC;

    logic                     sum_valid_reg;
    logic signed [PROD_W-1:0] d_reg;
    logic signed [PROD_W-1:0] nre_reg;
    logic signed [PROD_W-1:0] nim_reg;
    logic                     sum_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sum_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg        <= p_sc + prod_ro_reg;
            nre_reg      <= mul_swp_reg ? prod_xr_reg + y_sc : x_sc + prod_yr_reg;
            nim_reg      <= mul_swp_reg ? prod_yr_reg - x_sc : y_sc - prod_xr_reg;
            sum_zero_reg <= mul_zero_reg;
        end
    end

    // ---------------- magnitudes and signs ----------------
    logic [PROD_W-1:0] d_abs;
    logic [PROD_W-1:0] nre_abs;
    logic [PROD_W-1:0] nim_abs;
    assign d_abs   = d_reg[PROD_W-1]   ? $unsigned(-d_reg)   : $unsigned(d_reg);
    assign nre_abs = nre_reg[PROD_W-1] ? $unsigned(-nre_reg) : $unsigned(nre_reg);
    assign nim_abs = nim_reg[PROD_W-1] ? $unsigned(-nim_reg) : $unsigned(nim_reg);

    logic             mag_valid_reg;
    logic [MAG_W-1:0] dmag_reg;
    logic [MAG_W-1:0] nre_mag_reg;
    logic [MAG_W-1:0] nim_mag_reg;
    logic             nre_neg_reg;
    logic             nim_neg_reg;
    logic             mag_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mag_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmag_reg     <= d_abs[MAG_W-1:0];
            nre_mag_reg  <= nre_abs[MAG_W-1:0];
            nim_mag_reg  <= nim_abs[MAG_W-1:0];
            nre_neg_reg  <= nre_reg[PROD_W-1] != d_reg[PROD_W-1];
            nim_neg_reg  <= nim_reg[PROD_W-1] != d_reg[PROD_W-1];
            mag_zero_reg <= sum_zero_reg;
        end
    end

    // quotient of 2^33 or more saturates either way
    localparam int OVF_W = MAG_W + PQ_BITS - Q_FRAC;
    logic [OVF_W-1:0] dmag_top;
    re_side_t         re_side_in;
    part_side_t       im_side_in;

    always_comb
    begin
        dmag_top             = {dmag_reg, {(PQ_BITS - Q_FRAC){1'b0}}};
        re_side_in.zero      = mag_zero_reg;
        re_side_in.part.neg  = nre_neg_reg;
        re_side_in.part.ovf  = OVF_W'(nre_mag_reg) >= dmag_top;
        im_side_in.neg       = nim_neg_reg;
        im_side_in.ovf       = OVF_W'(nim_mag_reg) >= dmag_top;
    end

    // ---------------- part divides |N| * 2^16 / |D| ----------------
    logic               pre_valid_unused_re;
    logic               pre_valid_unused_im;
    logic [PQ_BITS-1:0] re_quot;
    logic [PQ_BITS-1:0] im_quot;
    logic [$bits(re_side_t)-1:0]   re_side_bits;
    logic [$bits(part_side_t)-1:0] im_side_bits;

    cdiv_udiv #(
        .QB(PQ_BITS),
        .DW(MAG_W),
        .SW($bits(re_side_t))
    ) u_part_re (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (mag_valid_reg),
        .in_rem   ({{(PRW - MAG_W - Q_FRAC){1'b0}}, nre_mag_reg, {Q_FRAC{1'b0}}}),
        .in_div   (dmag_reg),
        .in_side  (re_side_in),
        .out_valid(pre_valid_unused_re),
        .out_quot (re_quot),
        .out_side (re_side_bits)
    );

    cdiv_udiv #(
        .QB(PQ_BITS),
        .DW(MAG_W),
        .SW($bits(part_side_t))
    ) u_part_im (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (mag_valid_reg),
        .in_rem   ({{(PRW - MAG_W - Q_FRAC){1'b0}}, nim_mag_reg, {Q_FRAC{1'b0}}}),
        .in_div   (dmag_reg),
        .in_side  (im_side_in),
        .out_valid(pre_valid_unused_im),
        .out_quot (im_quot),
        .out_side (im_side_bits)
    );

    // ---------------- sign and saturation ----------------
    function automatic logic [WORD_W:0] clamp_part(
        input logic [PQ_BITS-1:0] q,
        input part_side_t         s
    );
        logic [WORD_W:0] res;
        if (s.neg)
        begin
            if (s.ovf || (q > PQ_BITS'(NEG_MAX)))
                res = {1'b1, NEG_MAX};
            else
                res = {1'b0, WORD_W'(-q)};
        end
        else
        begin
            if (s.ovf || (q > PQ_BITS'(POS_MAX)))
                res = {1'b1, POS_MAX};
            else
                res = {1'b0, q[WORD_W-1:0]};
        end
        return res;
    endfunction

    re_side_t        re_side;
    logic [WORD_W:0] re_fin;
    logic [WORD_W:0] im_fin;
    logic            fin_valid;

    always_comb
    begin
        re_side   = re_side_t'(re_side_bits);
        re_fin    = clamp_part(re_quot, re_side.part);
        im_fin    = clamp_part(im_quot, part_side_t'(im_side_bits));
        fin_valid = pre_valid_unused_re && pre_valid_unused_im;
    end

    // ---------------- output register ----------------
    logic [WORD_W-1:0] quot_re_reg;
    logic [WORD_W-1:0] quot_im_reg;
    logic              dbz_reg;
    logic              sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= fin_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (re_side.zero)
            begin
                // zero divisor: both parts pinned at the top
                quot_re_reg <= POS_MAX;
                quot_im_reg <= POS_MAX;
                dbz_reg     <= 1'b1;
                sat_reg     <= 1'b0;
            end
            else
            begin
                quot_re_reg <= re_fin[WORD_W-1:0];
                quot_im_reg <= im_fin[WORD_W-1:0];
                dbz_reg     <= 1'b0;
                sat_reg     <= re_fin[WORD_W] || im_fin[WORD_W];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign quot_re     = $signed(quot_re_reg);
    assign quot_im     = $signed(quot_im_reg);
    assign div_by_zero = dbz_reg;
    assign saturated   = sat_reg;

    // ---------------- assertions ----------------
    a_dbz_pinned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_by_zero |->
            !saturated && quot_re_reg == POS_MAX && quot_im_reg == POS_MAX)
        else $error("zero divisor result not pinned");

    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            quot_re_reg == POS_MAX || quot_re_reg == NEG_MAX ||
            quot_im_reg == POS_MAX || quot_im_reg == NEG_MAX)
        else $error("saturation flag without a clamped part");

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        pre_valid_unused_re == pre_valid_unused_im)
        else $error("part divider lanes out of step");

endmodule
`default_nettype wire

[bench/complex_divide_test.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// complex_divide_test
// self-checking bench for the pipelined Smith complex divider: directed
// corner divisors and dividends, then bursts of random operands with
// random receiver stalls and one long output hold-off
// ----------------------------------------------------------------------------
module complex_divide_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cdiv_pkg::*;

    localparam int  LATENCY     = 69;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  N_RANDOM    = 1200;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] num_re;
    logic signed [31:0] num_im;
    logic signed [31:0] den_re;
    logic signed [31:0] den_im;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] quot_re;
    logic signed [31:0] quot_im;
    logic               div_by_zero;
    logic               saturated;

    // one expected quotient transaction
    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic        dbz;
        logic        sat;
    } quotient_t;

    quotient_t   quotients_due[$];
    int          errors;
    int          sent;
    int          received;
    int          zero_divs;
    int          sat_count;
    int          cycles;
    bit          hold_off;
    int          hold_cycles;

    complex_divide uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .num_re     (num_re),
        .num_im     (num_im),
        .den_re     (den_re),
        .den_im     (den_im),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .quot_re    (quot_re),
        .quot_im    (quot_im),
        .div_by_zero(div_by_zero),
        .saturated  (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // magnitude of a signed 64-bit value as unsigned
    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // one saturated Q16.16 quotient part from numerator n and denominator d
    function automatic logic [31:0] scale_part(input logic signed [63:0] n,
                                               input logic signed [63:0] d,
                                               inout logic sat);
        logic [63:0] nm;
        logic [63:0] dm;
        logic [63:0] q;
        logic [63:0] rem;
        logic        neg;
        nm  = abs64(n);
        dm  = abs64(d);
        neg = n[63] ^ d[63];
        q   = nm / dm;
        rem = nm % dm;
        for (int i = 0; i < Q_FRAC; i++)
        begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= dm)
            begin
                rem  = rem - dm;
                q[0] = 1'b1;
            end
        end
        if (neg)
        begin
            if (q > 64'h8000_0000)
            begin
                sat = 1'b1;
                return NEG_MAX;
            end
            return 32'(-q);
        end
        if (q > 64'h7FFF_FFFF)
        begin
            sat = 1'b1;
            return POS_MAX;
        end
        return q[31:0];
    endfunction

    // smith division of (x + jy) by (a + jb)
    function automatic quotient_t smith_quotient(input logic signed [31:0] x,
                                                 input logic signed [31:0] y,
                                                 input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        quotient_t         q;
        logic signed [63:0] xl, yl, al, bl, r, d, nre, nim;
        logic               sat;
        xl  = x;
        yl  = y;
        al  = a;
        bl  = b;
        sat = 1'b0;
        q.dbz = 1'b0;
        if (abs64(al) >= abs64(bl))
        begin
            if (al == 0)
            begin
                q.re  = POS_MAX;
                q.im  = POS_MAX;
                q.dbz = 1'b1;
                q.sat = 1'b0;
                return q;
            end
            // real part is the pivot (also on equal magnitudes)
            r   = (bl <<< R_FRAC) / al;
            d   = (al <<< R_FRAC) + r * bl;
            nre = (xl <<< R_FRAC) + yl * r;
            nim = (yl <<< R_FRAC) - xl * r;
        end
        else
        begin
            r   = (al <<< R_FRAC) / bl;
            d   = (bl <<< R_FRAC) + r * al;
            nre = xl * r + (yl <<< R_FRAC);
            nim = yl * r - (xl <<< R_FRAC);
        end
        q.re  = scale_part(nre, d, sat);
        q.im  = scale_part(nim, d, sat);
        q.sat = sat;
        return q;
    endfunction

    // offer one transaction and wait until it is taken
    task automatic send_division(input logic [31:0] x, input logic [31:0] y,
                                 input logic [31:0] a, input logic [31:0] b);
        in_valid <= 1'b1;
        num_re   <= x;
        num_im   <= y;
        den_re   <= a;
        den_im   <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        quotients_due.push_back(smith_quotient(x, y, a, b));
        sent++;
    endtask

    task automatic idle_cycles(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // random word biased toward small values, extremes and full range
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return POS_MAX;
            1:       return NEG_MAX;
            2:       return 32'(int'($urandom_range(0, 8)) - 4);
            3, 4:    return 32'(int'($urandom_range(0, 32'h3_0000)) - 32'h1_8000);
            default: return $urandom();
        endcase
    endfunction

    // an extreme value in every field and each special case of the method
    task automatic test_directed();
        send_division(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
        send_division(32'h0003_0000, 32'h0004_0000, 32'h0000_0000, 32'h0000_0000);
        send_division(POS_MAX, NEG_MAX, 32'h0, 32'h0);
        send_division(POS_MAX, POS_MAX, 32'h0000_0001, 32'h0);
        send_division(NEG_MAX, NEG_MAX, 32'h0000_0001, 32'h0000_0001);
        send_division(NEG_MAX, 32'h0, 32'hFFFF_FFFF, 32'h0);
        send_division(POS_MAX, NEG_MAX, NEG_MAX, NEG_MAX);
        send_division(NEG_MAX, POS_MAX, POS_MAX, NEG_MAX);
        send_division(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000);
        send_division(32'h0001_0000, 32'h0, 32'h0, NEG_MAX);
        send_division(32'hFFFF_0000, 32'h0005_0000, 32'h0001_0000, 32'hFFFF_0000);
        send_division(32'h0, 32'h0, POS_MAX, 32'h1234_5678);
        send_division(32'h1234_5678, 32'h8765_4321, 32'h0000_0003, 32'h0000_0007);
        send_division(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
        send_division(32'h0000_8000, 32'hFFFF_8000, 32'h0002_0000, 32'hFFFE_0000);
        send_division(32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 32'hFFFF_FFFF);
        idle_cycles(3);
    endtask

    // random bursts; the receiver stalls on its own pattern
    task automatic test_random();
        int burst;
        while (sent < N_RANDOM + 16)
        begin
            burst = $urandom_range(1, 40);
            repeat (burst) send_division(pick_word(), pick_word(), pick_word(),
                                         pick_word());
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 6));
        end
        idle_cycles(1);
    endtask

    // long output hold-off while the sender keeps offering
    task automatic test_backpressure();
        hold_cycles = 300;
        hold_off    = 1'b1;
        repeat (150) send_division(pick_word(), pick_word(), pick_word(), pick_word());
        idle_cycles(1);
    endtask

    // receiver stall pattern: quiet stretches, random stalls, long holds
    initial
    begin
        int phase;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
                if (hold_cycles <= 0)
                    hold_off = 1'b0;
            end
            else
            begin
                phase = (cycles / 500) % 3;
                if (phase == 0)
                    out_stall <= 1'b0;
                else if (phase == 1)
                    out_stall <= ($urandom_range(0, 3) == 0);
                else
                    out_stall <= ($urandom_range(0, 1) == 0);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        quotient_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            received++;
            if (quotients_due.size() == 0)
            begin
                $error("result with no transaction pending");
                errors++;
            end
            else
            begin
                e = quotients_due.pop_front();
                if (e.dbz)
                    zero_divs++;
                if (e.sat)
                    sat_count++;
                if (quot_re !== e.re)
                begin
                    $error("quot_re expected %h actual %h", e.re, quot_re);
                    errors++;
                end
                if (quot_im !== e.im)
                begin
                    $error("quot_im expected %h actual %h", e.im, quot_im);
                    errors++;
                end
                if (div_by_zero !== e.dbz)
                begin
                    $error("div_by_zero expected %b actual %b", e.dbz, div_by_zero);
                    errors++;
                end
                if (saturated !== e.sat)
                begin
                    $error("saturated expected %b actual %b", e.sat, saturated);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        errors   = 0;
        sent     = 0;
        received = 0;
        cycles   = 0;
        hold_off = 1'b0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        num_re   = '0;
        num_im   = '0;
        den_re   = '0;
        den_im   = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random();
        while (quotients_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        $display("sent %0d divisions, checked %0d quotients", sent, received);
        $display("zero divisors %0d, saturated results %0d", zero_divs, sat_count);
        if (errors == 0 && quotients_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
